/* src/stl_pkg.sv */
// Package for the source token lexer: token class codes, character codes,
// the keyword and symbol tables and the small helper functions around them.
// No dependencies.
package stl_pkg;

    // Token classes as they appear on the result channel.
    localparam logic [2:0] CLASS_KEYWORD = 3'd0;
    localparam logic [2:0] CLASS_SYMBOL  = 3'd1;
    localparam logic [2:0] CLASS_INTEGER = 3'd2;
    localparam logic [2:0] CLASS_STRING  = 3'd3;
    localparam logic [2:0] CLASS_IDENT   = 3'd4;
    localparam logic [2:0] CLASS_INVALID = 3'd5;

    localparam int          NUM_KW      = 21;
    localparam logic [4:0]  NO_KEYWORD  = 5'd21;
    localparam logic [14:0] INT_MAX_VAL = 15'd32767;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Keyword spellings, right-justified: character p of a word of length n
    // sits in byte n-1-p.
    localparam logic [87:0] KW_WORD [NUM_KW] = '{
        88'("class"), 88'("constructor"), 88'("function"), 88'("method"),
        88'("field"), 88'("static"), 88'("var"), 88'("int"), 88'("char"),
        88'("boolean"), 88'("void"), 88'("true"), 88'("false"), 88'("null"),
        88'("this"), 88'("let"), 88'("do"), 88'("if"), 88'("else"),
        88'("while"), 88'("return")
    };

    localparam int KW_LEN [NUM_KW] = '{
        5, 11, 8, 6, 5, 6, 3, 3, 4, 7, 4, 4, 5, 4, 4, 3, 2, 2, 4, 5, 6
    };

    localparam logic [7:0] SYM_TABLE [19] = '{
        8'h7b, 8'h7d, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h2e, 8'h2c, 8'h3b, 8'h2b,
        8'h2d, 8'h2a, 8'h2f, 8'h26, 8'h7c, 8'h3c, 8'h3e, 8'h3d, 8'h7e
    };

    // One token request from the front end to the emit sequencer.
    typedef struct packed {
        logic        start;
        logic [2:0]  cls;
        logic [4:0]  kw;
        logic [14:0] ival;
        logic        iovf;
        logic        trunc;
        logic        tail_en;
        logic [2:0]  tail_cls;
        logic [7:0]  tail_ch;
        logic        tail_valid;
        logic        tail_trunc;
    } emit_req_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
               is_digit(c) || (c == 8'h5f);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 19; i++)
        begin
            if (SYM_TABLE[i] == c)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // True when character c matches keyword idx at position pos.
    function automatic logic kw_match(input int idx, input int pos, input logic [7:0] c);
        if (pos >= KW_LEN[idx])
            return 1'b0;
        return KW_WORD[idx][8*(KW_LEN[idx]-1-pos) +: 8] == c;
    endfunction

endpackage

/* src/stl_ifs.sv */
// Channel interfaces of the source token lexer: the character input channel
// and the token result channel. No dependencies.
interface stl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_char;

    modport source (output valid, output source_char, input ready);
    modport sink   (input valid, input source_char, output ready);
endinterface

interface stl_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_class;
    logic [7:0]  token_char;
    logic        char_valid;
    logic [4:0]  keyword_id;
    logic [14:0] int_value;
    logic        int_overflow;
    logic        token_truncated;
    logic        token_last;
    logic        run_last;

    modport source (output valid, output token_class, output token_char,
                    output char_valid, output keyword_id, output int_value,
                    output int_overflow, output token_truncated,
                    output token_last, output run_last, input ready);
    modport sink   (input valid, input token_class, input token_char,
                    input char_valid, input keyword_id, input int_value,
                    input int_overflow, input token_truncated,
                    input token_last, input run_last, output ready);
endinterface

/* src/stl_token_ram.sv */
// Token character buffer: one write port, one read port, registered read.
// No dependencies.
module stl_token_ram #(
    parameter int MAX_TOKEN = 32
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_TOKEN)-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_TOKEN)-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [MAX_TOKEN];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* src/stl_emit_seq.sv */
// Emit sequencer: walks the token buffer one character at a time and drives
// the result register, then sends the trailing single beat if one is due.
// Depends on stl_pkg and stl_ifs.
module stl_emit_seq #(
    parameter int MAX_TOKEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stl_pkg::emit_req_t             req,
    input  logic [$clog2(MAX_TOKEN+1)-1:0] req_len,
    output logic                           busy,
    output logic                           rd_en,
    output logic [$clog2(MAX_TOKEN)-1:0]   rd_addr,
    input  logic [7:0]                     rd_data,
    stl_token_if.source                    tokens
);

    localparam int LW = $clog2(MAX_TOKEN+1);
    localparam int AW = $clog2(MAX_TOKEN);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic          state_reg, state_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] ld_idx_reg;
    logic          rd_pend_reg;
    logic          tail_pend_reg;
    stl_pkg::emit_req_t tok_reg;

    logic          out_valid_reg;
    logic [2:0]    out_cls_reg;
    logic [7:0]    out_ch_reg;
    logic          out_cv_reg;
    logic [4:0]    out_kw_reg;
    logic [14:0]   out_ival_reg;
    logic          out_iovf_reg;
    logic          out_trunc_reg;
    logic          out_tlast_reg;
    logic          out_rlast_reg;

    logic out_free;
    logic at_end;
    logic issue;
    logic load_tail;
    logic done;
    logic mem_last;

    // Beat scheduling.
    always_comb
    begin
        out_free  = !out_valid_reg || tokens.ready;
        at_end    = (idx_reg == len_reg);
        issue     = (state_reg == ST_EMIT) && !rd_pend_reg && !at_end && out_free;
        load_tail = (state_reg == ST_EMIT) && !rd_pend_reg && at_end && tail_pend_reg &&
                    out_free;
        done      = (state_reg == ST_EMIT) && !rd_pend_reg && at_end && !tail_pend_reg;
        mem_last  = (ld_idx_reg == (len_reg - LW'(1)));
    end

    assign rd_en   = issue;
    assign rd_addr = idx_reg[AW-1:0];
    assign busy    = (state_reg == ST_EMIT);

    // State transitions.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && req.start)
            begin
                idx_reg       <= '0;
                len_reg       <= req_len;
                tail_pend_reg <= req.tail_en;
            end
            else
            begin
                if (issue)
                    idx_reg <= idx_reg + LW'(1);
                if (load_tail)
                    tail_pend_reg <= 1'b0;
            end
            rd_pend_reg <= issue;
        end
    end

    // Token attributes and read index, no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req.start)
            tok_reg <= req;
        if (issue)
            ld_idx_reg <= idx_reg;
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rd_pend_reg || load_tail)
            out_valid_reg <= 1'b1;
        else if (tokens.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_cls_reg   <= tok_reg.cls;
            out_ch_reg    <= rd_data;
            out_cv_reg    <= 1'b1;
            out_kw_reg    <= tok_reg.kw;
            out_ival_reg  <= tok_reg.ival;
            out_iovf_reg  <= tok_reg.iovf;
            out_trunc_reg <= tok_reg.trunc;
            out_tlast_reg <= mem_last;
            out_rlast_reg <= mem_last && !tail_pend_reg;
        end
        else if (load_tail)
        begin
            out_cls_reg   <= tok_reg.tail_cls;
            out_ch_reg    <= tok_reg.tail_ch;
            out_cv_reg    <= tok_reg.tail_valid;
            out_kw_reg    <= stl_pkg::NO_KEYWORD;
            out_ival_reg  <= '0;
            out_iovf_reg  <= 1'b0;
            out_trunc_reg <= tok_reg.tail_trunc;
            out_tlast_reg <= 1'b1;
            out_rlast_reg <= 1'b1;
        end
    end

    assign tokens.valid           = out_valid_reg;
    assign tokens.token_class     = out_cls_reg;
    assign tokens.token_char      = out_ch_reg;
    assign tokens.char_valid      = out_cv_reg;
    assign tokens.keyword_id      = out_kw_reg;
    assign tokens.int_value       = out_ival_reg;
    assign tokens.int_overflow    = out_iovf_reg;
    assign tokens.token_truncated = out_trunc_reg;
    assign tokens.token_last      = out_tlast_reg;
    assign tokens.run_last        = out_rlast_reg;

endmodule

/* src/source_token_lexer_core.sv */
// Top level of the source token lexer: character classification, token
// state and keyword tracking. Depends on stl_pkg, stl_ifs, stl_token_ram
// and stl_emit_seq.
//
// One source character is taken per cycle while no token is being sent.
// A character that ends a token stops intake until the last beat of the
// token is loaded into the result register: each buffered character takes
// a read of the token buffer and then a load of the result register, and
// a trailing symbol, invalid or empty-string beat is loaded after them.
// Results are held in a register, so a character that produces nothing is
// accepted even while a beat still waits on the result channel. Keywords
// are recognised as characters arrive, so no extra pass over the buffer
// is needed.
module source_token_lexer_core #(
    parameter int MAX_TOKEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    stl_char_if.sink    chars,
    stl_token_if.source tokens
);

    localparam int LW = $clog2(MAX_TOKEN+1);
    localparam int AW = $clog2(MAX_TOKEN);

    logic                       in_string_reg;
    logic [LW-1:0]              len_reg;
    logic                       all_digits_reg;
    logic [14:0]                value_reg;
    logic                       vovf_reg;
    logic                       lovf_reg;
    logic [stl_pkg::NUM_KW-1:0] cand_reg;
    logic [stl_pkg::NUM_KW-1:0] cand_next;

    logic        busy;
    logic        accept;
    logic [7:0]  c;
    logic        c_quote, c_lf, c_word, c_digit, c_space;
    logic        do_append, room;
    logic        str_close, word_flush, open_str;
    logic [18:0] v_full;
    logic [14:0] v_sat;
    logic        v_ovf;
    logic [stl_pkg::NUM_KW-1:0] kw_hit;
    logic        kw_found;
    logic [4:0]  kw_id;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]  rd_data;
    stl_pkg::emit_req_t req;

    assign chars.ready = !busy;
    assign accept      = chars.valid && !busy;
    assign c           = chars.source_char;

    // Character classification.
    always_comb
    begin
        c_quote   = (c == stl_pkg::CHAR_QUOTE);
        c_lf      = (c == stl_pkg::CHAR_LF);
        c_word    = stl_pkg::is_word_char(c);
        c_digit   = stl_pkg::is_digit(c);
        c_space   = stl_pkg::is_space(c);
        do_append = in_string_reg ? (!c_quote && !c_lf) : c_word;
        room      = (len_reg < LW'(MAX_TOKEN));
        str_close = in_string_reg && c_quote;
        open_str  = !in_string_reg && c_quote;
        word_flush = !in_string_reg && !c_word;
    end

    // Running decimal value, saturated.
    always_comb
    begin
        v_full = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1) +
                 19'(c - stl_pkg::CHAR_ZERO);
        v_ovf  = (v_full > 19'(stl_pkg::INT_MAX_VAL));
        v_sat  = v_ovf ? stl_pkg::INT_MAX_VAL : v_full[14:0];
    end

    // Keyword candidates narrowed one character at a time.
    always_comb
    begin
        for (int i = 0; i < stl_pkg::NUM_KW; i++)
        begin
            cand_next[i] = cand_reg[i] && stl_pkg::kw_match(i, int'(len_reg), c);
            kw_hit[i]    = cand_reg[i] && (int'(len_reg) == stl_pkg::KW_LEN[i]);
        end
    end

    // First matching keyword.
    always_comb
    begin
        kw_found = 1'b0;
        kw_id    = stl_pkg::NO_KEYWORD;
        for (int i = stl_pkg::NUM_KW - 1; i >= 0; i--)
        begin
            if (kw_hit[i])
            begin
                kw_found = 1'b1;
                kw_id    = 5'(i);
            end
        end
    end

    // Token request to the emit sequencer.
    always_comb
    begin
        req            = '0;
        req.kw         = stl_pkg::NO_KEYWORD;
        req.trunc      = lovf_reg;
        req.tail_ch    = c;
        req.tail_valid = 1'b1;
        req.tail_cls   = stl_pkg::is_symbol(c) ? stl_pkg::CLASS_SYMBOL
                                               : stl_pkg::CLASS_INVALID;
        if (str_close)
        begin
            req.cls        = stl_pkg::CLASS_STRING;
            req.tail_en    = (len_reg == '0);
            req.tail_cls   = stl_pkg::CLASS_STRING;
            req.tail_ch    = 8'h00;
            req.tail_valid = 1'b0;
            req.tail_trunc = lovf_reg;
            req.start      = accept;
        end
        else
        begin
            if (kw_found && !lovf_reg)
            begin
                req.cls = stl_pkg::CLASS_KEYWORD;
                req.kw  = kw_id;
            end
            else if (all_digits_reg)
            begin
                req.cls  = stl_pkg::CLASS_INTEGER;
                req.ival = value_reg;
                req.iovf = vovf_reg;
            end
            else
            begin
                req.cls = stl_pkg::CLASS_IDENT;
            end
            req.tail_en    = word_flush && !open_str && !c_space;
            req.tail_trunc = 1'b0;
            req.start      = accept && word_flush && ((len_reg != '0) || req.tail_en);
        end
    end

    // Token state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg  <= 1'b0;
            len_reg        <= '0;
            all_digits_reg <= 1'b1;
            value_reg      <= '0;
            vovf_reg       <= 1'b0;
            lovf_reg       <= 1'b0;
            cand_reg       <= '1;
        end
        else if (accept)
        begin
            if (str_close || word_flush)
            begin
                len_reg        <= '0;
                all_digits_reg <= 1'b1;
                value_reg      <= '0;
                vovf_reg       <= 1'b0;
                lovf_reg       <= 1'b0;
                cand_reg       <= '1;
                if (str_close)
                    in_string_reg <= 1'b0;
                else if (open_str)
                    in_string_reg <= 1'b1;
            end
            else if (do_append)
            begin
                if (room)
                    len_reg <= len_reg + LW'(1);
                else
                    lovf_reg <= 1'b1;
                if (!in_string_reg)
                begin
                    cand_reg <= cand_next;
                    if (c_digit)
                    begin
                        if (all_digits_reg)
                        begin
                            value_reg <= v_sat;
                            if (v_ovf)
                                vovf_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        all_digits_reg <= 1'b0;
                    end
                end
            end
        end
    end

    stl_token_ram #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && !str_close && !word_flush && do_append && room),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (c),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stl_emit_seq #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .req_len (len_reg),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .tokens  (tokens)
    );

endmodule

/* src/stl_checker.sv */
// Port-level checker for the source token lexer and its bind to the top
// level. Depends on stl_pkg and source_token_lexer_core.
module stl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  token_class,
    input logic        char_valid,
    input logic [4:0]  keyword_id,
    input logic [14:0] int_value,
    input logic        int_overflow,
    input logic        token_last,
    input logic        run_last
);

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // Keyword class and keyword index agree.
    a_kw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_class == stl_pkg::CLASS_KEYWORD) ==
                       (keyword_id != stl_pkg::NO_KEYWORD)))
        else $error("keyword index does not match class");

    // Value fields are only used by integer tokens.
    a_int: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_class != stl_pkg::CLASS_INTEGER) |->
            (int_value == '0) && !int_overflow)
        else $error("integer fields set on a non-integer beat");

    // The last beat of a run closes its token.
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> token_last)
        else $error("run ends inside a token");

    // An empty beat is only the single beat of an empty string.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |->
            (token_class == stl_pkg::CLASS_STRING) && token_last)
        else $error("empty beat outside an empty string");

endmodule

bind source_token_lexer_core stl_checker u_stl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .token_class  (tokens.token_class),
    .char_valid   (tokens.char_valid),
    .keyword_id   (tokens.keyword_id),
    .int_value    (tokens.int_value),
    .int_overflow (tokens.int_overflow),
    .token_last   (tokens.token_last),
    .run_last     (tokens.run_last)
);
